[hdl/bffta_pkg.sv]
package bffta_pkg;

    localparam int MaxFiles = 16;
    localparam int IdxW = 4;
    localparam int CntW = 5;
    localparam int AddrW = 24;
    localparam int KeyW = 64;

    localparam logic [2:0] MODE_CLEAR  = 3'd0;
    localparam logic [2:0] MODE_CREATE = 3'd1;
    localparam logic [2:0] MODE_DELETE = 3'd2;
    localparam logic [2:0] MODE_LOOKUP = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NO_SPACE  = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;

    localparam logic [1:0] REG_DEVICE   = 2'd0;
    localparam logic [1:0] REG_PAGE     = 2'd1;
    localparam logic [1:0] REG_RESERVED = 2'd2;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // latch request, normalize key
        OP_SCAN,      // compare key of entry r_ptr
        OP_SHDN,      // move entry ptr+1 to ptr
        OP_GAPS,      // compute gap start (remainder unit start)
        OP_GAPE,      // evaluate gap end / best fit
        OP_SHUP,      // move entry ptr-1 to ptr
        OP_INS,       // write new entry at ptr
        OP_READ,      // latch entry ptr as result
        OP_DECCNT,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [IdxW-1:0] ptr;
    } t_cmd;

    typedef struct packed {
        logic            match;    // key of scanned entry matches
        logic            rem_done; // remainder unit finished
        logic            found;    // a fitting gap exists
        logic [IdxW-1:0] best;
        logic [CntW-1:0] count;
        logic [2:0]      mode;
        logic [IdxW-1:0] eidx;
    } t_stat;

    function automatic logic [KeyW-1:0] norm_key(input logic [KeyW-1:0] k);
        logic [KeyW-1:0] o;
        logic            stop;
        o = '0;
        stop = 1'b0;
        for (int b = 7; b >= 0; b--) begin
            if (k[8*b +: 8] == 8'd0) stop = 1'b1;
            if (!stop) o[8*b +: 8] = k[8*b +: 8];
        end
        return o;
    endfunction

endpackage

[hdl/bffta_datapath.sv]
module bffta_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bffta_pkg::t_cmd            i_cmd,
    output bffta_pkg::t_stat           o_stat,
    input  logic                       i_cfg_valid,
    input  logic [1:0]                 i_cfg_index,
    input  logic [24:0]                i_cfg_data,
    input  logic [2:0]                 i_mode,
    input  logic [63:0]                i_name_key,
    input  logic [23:0]                i_file_size,
    input  logic [3:0]                 i_entry_index,
    input  logic                       i_res_err,
    output logic [3:0]                 o_index,
    output logic [23:0]                o_start_address,
    output logic [23:0]                o_size_out,
    output logic [63:0]                o_key_out
);
    localparam int IW = bffta_pkg::IdxW;

    logic [24:0] r_dev;
    logic [7:0]  r_page;
    logic [15:0] r_resv;

    logic [63:0] r_keys  [bffta_pkg::MaxFiles];
    logic [23:0] r_starts[bffta_pkg::MaxFiles];
    logic [23:0] r_sizes [bffta_pkg::MaxFiles];
    logic [bffta_pkg::CntW-1:0] r_count;

    logic [2:0]  r_mode;
    logic [63:0] r_key;
    logic [23:0] r_size;
    logic [3:0]  r_eidx;

    logic        r_found;
    logic [IW-1:0] r_best;
    logic [23:0] r_best_start;
    logic [24:0] r_best_gap;

    // remainder unit: restoring, one bit per cycle
    logic [24:0] r_num;
    logic [24:0] r_num_orig;
    logic [24:0] r_rem;
    logic [4:0]  r_bit;
    logic        r_rem_busy;
    logic [7:0]  pg;
    logic [25:0] rem_sh;
    logic [25:0] rem_sub;
    logic [24:0] s_al;
    logic [24:0] gap_end;
    logic [24:0] gap;
    logic        fits;

    logic [IW-1:0] ptr;
    logic [IW-1:0] ptr_m1;
    logic [IW-1:0] ptr_p1;

    assign ptr    = i_cmd.ptr;
    assign ptr_m1 = ptr - IW'(1);
    assign ptr_p1 = ptr + IW'(1);
    assign pg     = (r_page == 8'd0) ? 8'd1 : r_page;
    assign rem_sh = {r_rem, r_num[24]};
    assign rem_sub = rem_sh - {18'd0, pg};

    // aligned start from finished remainder
    assign s_al = (r_rem == 25'd0) ? r_num_orig
                : r_num_orig - r_rem + {17'd0, pg};

    assign gap_end = ({1'b0, ptr} == r_count[IW:0]) ? r_dev : {1'b0, r_starts[ptr]};
    assign gap  = gap_end - s_al;
    assign fits = !(gap_end < s_al) && !s_al[24] && (gap >= {1'b0, r_size});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev      <= 25'd32768;
            r_page     <= 8'd64;
            r_resv     <= 16'd256;
            r_count    <= '0;
            r_rem_busy <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bffta_pkg::REG_DEVICE:   r_dev  <= i_cfg_data;
                    bffta_pkg::REG_PAGE:     r_page <= i_cfg_data[7:0];
                    bffta_pkg::REG_RESERVED: r_resv <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (r_rem_busy) begin
                r_rem <= rem_sub[25] ? rem_sh[24:0] : rem_sub[24:0];
                r_num <= {r_num[23:0], 1'b0};
                r_bit <= r_bit - 5'd1;
                if (r_bit == 5'd0) r_rem_busy <= 1'b0;
            end
            case (i_cmd.op)
                bffta_pkg::OP_LOAD: begin
                    r_mode  <= i_mode;
                    r_key   <= bffta_pkg::norm_key(i_name_key);
                    r_size  <= i_file_size;
                    r_eidx  <= i_entry_index;
                    r_found <= 1'b0;
                    r_best  <= '0;
                    r_best_start <= '0;
                    r_best_gap   <= '0;
                end
                bffta_pkg::OP_SHDN: begin
                    r_keys[ptr]   <= r_keys[ptr_p1];
                    r_starts[ptr] <= r_starts[ptr_p1];
                    r_sizes[ptr]  <= r_sizes[ptr_p1];
                end
                bffta_pkg::OP_DECCNT: r_count <= r_count - 5'd1;
                bffta_pkg::OP_CLEAR:  r_count <= '0;
                bffta_pkg::OP_GAPS: begin
                    if (ptr == '0) r_num <= {9'd0, r_resv};
                    else r_num <= {1'b0, r_starts[ptr_m1]} + {1'b0, r_sizes[ptr_m1]};
                    if (ptr == '0) r_num_orig <= {9'd0, r_resv};
                    else r_num_orig <= {1'b0, r_starts[ptr_m1]} + {1'b0, r_sizes[ptr_m1]};
                    r_rem      <= '0;
                    r_bit      <= 5'd24;
                    r_rem_busy <= 1'b1;
                end
                bffta_pkg::OP_GAPE: begin
                    if (fits && (!r_found || gap < r_best_gap)) begin
                        r_found      <= 1'b1;
                        r_best       <= ptr;
                        r_best_start <= s_al[23:0];
                        r_best_gap   <= gap;
                    end
                end
                bffta_pkg::OP_SHUP: begin
                    r_keys[ptr]   <= r_keys[ptr_m1];
                    r_starts[ptr] <= r_starts[ptr_m1];
                    r_sizes[ptr]  <= r_sizes[ptr_m1];
                end
                bffta_pkg::OP_INS: begin
                    r_keys[ptr]   <= r_key;
                    r_starts[ptr] <= r_best_start;
                    r_sizes[ptr]  <= r_size;
                    r_count       <= r_count + 5'd1;
                end
                default: ;
            endcase
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == bffta_pkg::OP_READ) begin
            if (i_res_err) begin
                o_index <= '0; o_start_address <= '0; o_size_out <= '0; o_key_out <= '0;
            end else begin
                o_index         <= ptr;
                o_start_address <= r_starts[ptr];
                o_size_out      <= r_sizes[ptr];
                o_key_out       <= r_keys[ptr];
            end
        end
    end

    assign o_stat.match    = (r_keys[ptr] == r_key);
    assign o_stat.rem_done = !r_rem_busy;
    assign o_stat.found    = r_found;
    assign o_stat.best     = r_best;
    assign o_stat.count    = r_count;
    assign o_stat.mode     = r_mode;
    assign o_stat.eidx     = r_eidx;
endmodule

[hdl/bffta_ctrl.sv]
module bffta_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  bffta_pkg::t_stat  i_stat,
    output bffta_pkg::t_cmd   o_cmd,
    output logic              o_res_err,
    output logic              o_done,
    output logic [2:0]        o_status
);
    localparam int IW = bffta_pkg::IdxW;
    localparam logic [IW:0] PtrOne = (IW+1)'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_SCAN, S_SHDN, S_CHKFULL,
        S_GAPS, S_GAPW, S_GAPE, S_PLACE, S_SHUP, S_INS, S_OUT, S_DONE
    } t_state;

    t_state        r_state;
    logic [IW:0]   r_ptr;
    logic [IW-1:0] r_hit;
    logic          r_have;
    logic [2:0]    r_st;
    logic          r_err;
    logic [IW-1:0] r_optr;

    logic [2:0] mode;
    logic [bffta_pkg::CntW-1:0] cnt;
    assign mode = i_stat.mode;
    assign cnt  = i_stat.count;

    always_comb begin
        o_cmd.op  = bffta_pkg::OP_NONE;
        o_cmd.ptr = r_ptr[IW-1:0];
        o_res_err = r_err;
        case (r_state)
            // request fields are captured at the accepting edge
            S_IDLE: if (i_start) o_cmd.op = bffta_pkg::OP_LOAD;
            S_SHDN: begin
                if (r_ptr + PtrOne < cnt) o_cmd.op = bffta_pkg::OP_SHDN;
                else o_cmd.op = bffta_pkg::OP_DECCNT;
            end
            S_GAPS: o_cmd.op = bffta_pkg::OP_GAPS;
            S_GAPE: o_cmd.op = bffta_pkg::OP_GAPE;
            S_SHUP: o_cmd.op = bffta_pkg::OP_SHUP;
            S_INS:  o_cmd.op = bffta_pkg::OP_INS;
            S_OUT: begin
                o_cmd.op  = bffta_pkg::OP_READ;
                o_cmd.ptr = r_optr;
            end
            S_DISPATCH: if (mode == bffta_pkg::MODE_CLEAR) o_cmd.op = bffta_pkg::OP_CLEAR;
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
            r_hit   <= '0;
            r_have  <= 1'b0;
            r_st    <= bffta_pkg::ST_OK;
            r_err   <= 1'b0;
            r_optr  <= '0;
            o_done  <= 1'b0;
            o_status <= bffta_pkg::ST_OK;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: if (i_start) r_state <= S_DISPATCH;
                S_DISPATCH: begin
                    r_ptr  <= '0;
                    r_have <= 1'b0;
                    r_st   <= bffta_pkg::ST_OK;
                    r_err  <= 1'b1;
                    r_optr <= '0;
                    case (mode)
                        bffta_pkg::MODE_CREATE, bffta_pkg::MODE_DELETE,
                        bffta_pkg::MODE_LOOKUP: r_state <= S_SCAN;
                        bffta_pkg::MODE_READ: begin
                            if ({1'b0, i_stat.eidx} >= cnt) begin
                                r_st <= bffta_pkg::ST_BAD_INDEX;
                            end else begin
                                r_err  <= 1'b0;
                                r_optr <= i_stat.eidx;
                            end
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_SCAN: begin
                    if (r_ptr >= cnt) begin
                        if (mode == bffta_pkg::MODE_CREATE) r_state <= S_CHKFULL;
                        else begin
                            r_st    <= bffta_pkg::ST_NOT_FOUND;
                            r_state <= S_OUT;
                        end
                    end else if (i_stat.match) begin
                        r_hit <= r_ptr[IW-1:0];
                        if (mode == bffta_pkg::MODE_LOOKUP) begin
                            r_err   <= 1'b0;
                            r_optr  <= r_ptr[IW-1:0];
                            r_state <= S_OUT;
                        end else if (mode == bffta_pkg::MODE_DELETE) begin
                            // report before shifting: latch result now
                            r_err   <= 1'b0;
                            r_optr  <= r_ptr[IW-1:0];
                            r_have  <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SHDN;
                        end
                    end else begin
                        r_ptr <= r_ptr + PtrOne;
                    end
                end
                S_SHDN: begin
                    if (r_ptr + PtrOne < cnt) r_ptr <= r_ptr + PtrOne;
                    else if (mode == bffta_pkg::MODE_CREATE) r_state <= S_CHKFULL;
                    else r_state <= S_DONE;
                end
                S_CHKFULL: begin
                    r_ptr <= '0;
                    if (cnt >= bffta_pkg::CntW'(bffta_pkg::MaxFiles)) begin
                        r_st    <= bffta_pkg::ST_FULL;
                        r_state <= S_OUT;
                    end else r_state <= S_GAPS;
                end
                S_GAPS: r_state <= S_GAPW;
                S_GAPW: if (i_stat.rem_done) r_state <= S_GAPE;
                S_GAPE: begin
                    if (r_ptr == cnt) r_state <= S_PLACE;
                    else begin
                        r_ptr   <= r_ptr + PtrOne;
                        r_state <= S_GAPS;
                    end
                end
                S_PLACE: begin
                    if (!i_stat.found) begin
                        r_st    <= bffta_pkg::ST_NO_SPACE;
                        r_state <= S_OUT;
                    end else begin
                        r_ptr   <= cnt;
                        r_state <= S_SHUP;
                    end
                end
                S_SHUP: begin
                    if (r_ptr[IW-1:0] == i_stat.best || r_ptr == '0) r_state <= S_INS;
                    else r_ptr <= r_ptr - PtrOne;
                end
                S_INS: begin
                    r_err   <= 1'b0;
                    r_optr  <= i_stat.best;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (r_have) begin
                        r_have  <= 1'b0;
                        r_ptr   <= {1'b0, r_hit};
                        r_state <= S_SHDN;
                    end else r_state <= S_DONE;
                end
                S_DONE: begin
                    o_done   <= 1'b1;
                    o_status <= r_st;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[hdl/best_fit_file_table_allocator.sv]
// Best-fit file table allocator: a directory of up to 16 files sorted by start
// address, each with an 8-byte name key, start and size; create places a file in
// the smallest page-aligned gap that holds it. A request is taken at a rising
// edge with start high and busy low, and its fields are captured at that edge.
// The result is on the output ports for exactly one cycle with o_done high and
// must be taken then, since the receiver cannot stall the block. Clear, read
// entry and ignored modes go straight to the result; lookup and delete scan
// the entries one at a time, and delete also shifts the later entries down.
// Create scans too, then tries each candidate gap (entries + 1 of them) and
// waits for each on the bit-serial remainder unit that aligns the gap start to
// the page size. Configuration writes are accepted every cycle (o_cfg_ready
// high) and belong between requests.
module best_fit_file_table_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [24:0] i_cfg_data,
    input  logic [2:0]  i_mode,
    input  logic [63:0] i_name_key,
    input  logic [23:0] i_file_size,
    input  logic [3:0]  i_entry_index,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [3:0]  o_index,
    output logic [23:0] o_start_address,
    output logic [23:0] o_size_out,
    output logic [63:0] o_key_out,
    output logic [4:0]  o_file_count
);
    bffta_pkg::t_cmd  cmd;
    bffta_pkg::t_stat stat;
    logic             res_err;

    assign o_cfg_ready  = 1'b1;
    assign o_file_count = stat.count;

    bffta_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_res_err    (res_err),
        .o_done       (o_done),
        .o_status     (o_status)
    );

    bffta_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_mode),
        .i_name_key      (i_name_key),
        .i_file_size     (i_file_size),
        .i_entry_index   (i_entry_index),
        .i_res_err       (res_err),
        .o_index         (o_index),
        .o_start_address (o_start_address),
        .o_size_out      (o_size_out),
        .o_key_out       (o_key_out)
    );
endmodule
